FILE: rtl/core/rtmmp_pkg.sv
// shared types and constants for the recurrence term matrix power block
package rtmmp_pkg;

  localparam int unsigned OUT_W = 10;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQR,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic [1:0] elem;
    logic       k;
  } tag_t;

  typedef struct packed {
    logic load;
    logic issue;
    op_e  op;
    tag_t tag;
    logic commit;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_lsb;
    logic pipe_busy;
  } sts_t;

endpackage

FILE: rtl/core/rtmmp_modmul.sv
// pipelined modular multiplier with constant-reciprocal reduction
module rtmmp_modmul #(
  parameter int unsigned MODULUS = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [((MODULUS > 4) ? $clog2(MODULUS) : 2)-1:0] a_i,
  input  logic [((MODULUS > 4) ? $clog2(MODULUS) : 2)-1:0] b_i,
  input  rtmmp_pkg::tag_t                   tag_i,
  output logic                              out_valid_o,
  output logic [((MODULUS > 4) ? $clog2(MODULUS) : 2)-1:0] res_o,
  output rtmmp_pkg::tag_t                   tag_o,
  output logic                              busy_o
);

  localparam int unsigned W  = (MODULUS > 4) ? $clog2(MODULUS) : 2;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned QW = 2 * PW;
  localparam int unsigned RW = W + 2;

  localparam logic [63:0]   RECIP_WIDE = (64'd1 << PW) / 64'(MODULUS);
  localparam logic [PW-1:0] RECIP      = RECIP_WIDE[PW-1:0];
  localparam logic [PW-1:0] MOD_P      = PW'(MODULUS);
  localparam logic [RW-1:0] MOD_R1     = RW'(MODULUS);
  localparam logic [RW-1:0] MOD_R2     = RW'(2 * MODULUS);

  logic            v1_q, v2_q, v3_q;
  rtmmp_pkg::tag_t tag1_q, tag2_q, tag3_q;
  logic [PW-1:0]   p1_q, p2_q, q2_q;
  logic [RW-1:0]   r3_q;

  logic [QW-1:0]   qfull;
  logic [PW-1:0]   qm;
  logic [PW-1:0]   rfull;
  logic [RW-1:0]   rcor;

  assign qfull = QW'(p1_q) * QW'(RECIP);
  assign qm    = PW'(q2_q * MOD_P);
  assign rfull = p2_q - qm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= PW'(a_i) * PW'(b_i);
    tag1_q <= tag_i;
    p2_q   <= p1_q;
    q2_q   <= qfull[QW-1:PW];
    tag2_q <= tag1_q;
    r3_q   <= rfull[RW-1:0];
    tag3_q <= tag2_q;
  end

  // quotient estimate is short by at most two
  always_comb begin
    if (r3_q >= MOD_R2) begin
      rcor = r3_q - MOD_R2;
    end else if (r3_q >= MOD_R1) begin
      rcor = r3_q - MOD_R1;
    end else begin
      rcor = r3_q;
    end
  end

  assign res_o       = rcor[W-1:0];
  assign tag_o       = tag3_q;
  assign out_valid_o = v3_q;
  assign busy_o      = v1_q | v2_q | v3_q;

endmodule

FILE: rtl/core/rtmmp_dp.sv
// datapath: exponent shifter, matrix registers and the shared modular multiplier
module rtmmp_dp #(
  parameter int unsigned EXP_BITS = 31,
  parameter int unsigned MODULUS  = 1000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [EXP_BITS-1:0]            exponent_i,
  input  rtmmp_pkg::cmd_t                cmd_i,
  output rtmmp_pkg::sts_t                sts_o,
  output logic                           done_o,
  output logic [rtmmp_pkg::OUT_W-1:0]    last_digits_o
);

  localparam int unsigned W  = (MODULUS > 4) ? $clog2(MODULUS) : 2;
  localparam int unsigned SW = W + 1;
  localparam int unsigned FW = W + 2;

  localparam logic [W-1:0]  C1     = W'(1 % MODULUS);
  localparam logic [W-1:0]  C3     = W'(3 % MODULUS);
  localparam logic [W-1:0]  C5     = W'(5 % MODULUS);
  localparam logic [SW-1:0] MOD_S  = SW'(MODULUS);
  localparam logic [FW-1:0] MOD_F1 = FW'(MODULUS);
  localparam logic [FW-1:0] MOD_F2 = FW'(2 * MODULUS);
  localparam logic [FW-1:0] MOD_FM = FW'(MODULUS - 1);

  typedef struct packed {
    logic [W-1:0] e00;
    logic [W-1:0] e01;
    logic [W-1:0] e10;
    logic [W-1:0] e11;
  } mat_t;

  function automatic logic [W-1:0] pick(mat_t m, logic [1:0] idx);
    logic [W-1:0] v;
    case (idx)
      2'd0:    v = m.e00;
      2'd1:    v = m.e01;
      2'd2:    v = m.e10;
      2'd3:    v = m.e11;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [EXP_BITS-1:0] n_q;
  mat_t                acc_q, base_q, t_q;
  logic                done_q;
  logic [rtmmp_pkg::OUT_W-1:0] out_q;

  logic [W-1:0]    op_a, op_b;
  logic            mm_valid;
  logic [W-1:0]    mm_res;
  rtmmp_pkg::tag_t mm_tag;
  logic            mm_busy;

  logic [SW-1:0]   sum;
  logic [W-1:0]    wb_val;
  logic [FW-1:0]   fin_raw;
  logic [FW-1:0]   fin_red;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      rtmmp_pkg::OP_MUL: begin
        op_a = pick(acc_q, {cmd_i.tag.elem[1], cmd_i.tag.k});
        op_b = pick(base_q, {cmd_i.tag.k, cmd_i.tag.elem[0]});
      end
      rtmmp_pkg::OP_SQR: begin
        op_a = pick(base_q, {cmd_i.tag.elem[1], cmd_i.tag.k});
        op_b = pick(base_q, {cmd_i.tag.k, cmd_i.tag.elem[0]});
      end
      rtmmp_pkg::OP_FIN: begin
        op_a = cmd_i.tag.k ? C1 : C3;
        op_b = pick(acc_q, {1'b0, cmd_i.tag.k});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  rtmmp_modmul #(
    .MODULUS(MODULUS)
  ) u_modmul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.issue),
    .a_i        (op_a),
    .b_i        (op_b),
    .tag_i      (cmd_i.tag),
    .out_valid_o(mm_valid),
    .res_o      (mm_res),
    .tag_o      (mm_tag),
    .busy_o     (mm_busy)
  );

  // second product of an element adds onto the first
  always_comb begin
    sum = SW'(pick(t_q, mm_tag.elem)) + SW'(mm_res);
    if (!mm_tag.k) begin
      wb_val = mm_res;
    end else if (sum >= MOD_S) begin
      wb_val = W'(sum - MOD_S);
    end else begin
      wb_val = sum[W-1:0];
    end
  end

  // (2a + m - 1) mod m
  always_comb begin
    fin_raw = (FW'(t_q.e00) << 1) + MOD_FM;
    if (fin_raw >= MOD_F2) begin
      fin_red = fin_raw - MOD_F2;
    end else if (fin_raw >= MOD_F1) begin
      fin_red = fin_raw - MOD_F1;
    end else begin
      fin_red = fin_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q        <= (exponent_i == '0) ? '0 : exponent_i - EXP_BITS'(1);
      acc_q.e00  <= C1;
      acc_q.e01  <= '0;
      acc_q.e10  <= '0;
      acc_q.e11  <= C1;
      base_q.e00 <= C3;
      base_q.e01 <= C5;
      base_q.e10 <= C1;
      base_q.e11 <= C3;
    end else begin
      if (cmd_i.shift) begin
        n_q <= n_q >> 1;
      end
      if (cmd_i.commit) begin
        if (cmd_i.op == rtmmp_pkg::OP_MUL) begin
          acc_q <= t_q;
        end else begin
          base_q <= t_q;
        end
      end
    end
    if (mm_valid) begin
      case (mm_tag.elem)
        2'd0:    t_q.e00 <= wb_val;
        2'd1:    t_q.e01 <= wb_val;
        2'd2:    t_q.e10 <= wb_val;
        2'd3:    t_q.e11 <= wb_val;
        default: t_q.e00 <= wb_val;
      endcase
    end
    if (cmd_i.finish) begin
      out_q <= rtmmp_pkg::OUT_W'(fin_red);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.n_lsb     = n_q[0];
  assign sts_o.pipe_busy = mm_busy;
  assign done_o          = done_q;
  assign last_digits_o   = out_q;

endmodule

FILE: rtl/core/rtmmp_ctrl.sv
// controller: walks the exponent bits and sequences products on the multiplier
module rtmmp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rtmmp_pkg::sts_t sts_i,
  output rtmmp_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BIT   = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam logic [2:0] LAST_MAT = 3'd7;
  localparam logic [2:0] LAST_FIN = 3'd1;

  logic [1:0]       state_q, state_d;
  rtmmp_pkg::op_e   op_q, op_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             last;

  assign last = (op_q == rtmmp_pkg::OP_FIN) ? (cnt_q == LAST_FIN) : (cnt_q == LAST_MAT);

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.tag.elem = cnt_q[2:1];
    cmd_o.tag.k    = cnt_q[0];
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BIT;
        end
      end
      ST_BIT: begin
        cnt_d   = '0;
        state_d = ST_ISSUE;
        if (sts_i.n_zero) begin
          op_d = rtmmp_pkg::OP_FIN;
        end else if (sts_i.n_lsb) begin
          op_d = rtmmp_pkg::OP_MUL;
        end else begin
          op_d = rtmmp_pkg::OP_SQR;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (last) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          case (op_q)
            rtmmp_pkg::OP_MUL: begin
              cmd_o.commit = 1'b1;
              op_d         = rtmmp_pkg::OP_SQR;
              cnt_d        = '0;
              state_d      = ST_ISSUE;
            end
            rtmmp_pkg::OP_SQR: begin
              cmd_o.commit = 1'b1;
              cmd_o.shift  = 1'b1;
              state_d      = ST_BIT;
            end
            rtmmp_pkg::OP_FIN: begin
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= rtmmp_pkg::OP_FIN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit || cmd_o.finish) |-> !sts_i.pipe_busy)
    else $error("matrix committed while products in flight");
  a_issue_after_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_o.issue) |-> ($past(state_q) == ST_BIT || $past(cmd_o.commit)))
    else $error("product issue without a sequencing step");
`endif

endmodule

FILE: rtl/core/recurrence_term_mod_by_matrix_power.sv
// top level: last digits of a linear recurrence term by 2x2 matrix power
//
//   channel   direction  handshake              payload
//   request   in         start high, busy low   exponent_i
//   result    out        done_o one-cycle pulse last_digits_o
//
// an item's run time grows with the bit length L of N-1 and with P, its count
// of set bits; a new request is taken only once busy has fallen again
// each bit costs a squaring and, when set, a multiply, eight products each
// through the one three-stage modular multiplier, drained before commit
// no state survives between requests; reset clears control state and strobes
// the result pulse cannot be held off and a new request may start in that cycle
module recurrence_term_mod_by_matrix_power #(
  parameter int unsigned EXP_BITS = 31,
  parameter int unsigned MODULUS  = 1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [EXP_BITS-1:0]         exponent_i,
  output logic                        done_o,
  output logic [rtmmp_pkg::OUT_W-1:0] last_digits_o
);

  rtmmp_pkg::cmd_t cmd;
  rtmmp_pkg::sts_t sts;

  rtmmp_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  rtmmp_dp #(
    .EXP_BITS(EXP_BITS),
    .MODULUS (MODULUS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exponent_i   (exponent_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .last_digits_o(last_digits_o)
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((MODULUS > 1024) || (32'(last_digits_o) < MODULUS)))
    else $error("result not reduced");
`endif

endmodule

FILE: tb/sv/last_digits_checker.sv
`timescale 1ns / 1ps
// result checker for the matrix power block: predicts last digits per request and compares
module last_digits_checker #(
  parameter int unsigned EXP_BITS = 31,
  parameter int unsigned MODULUS  = 1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [EXP_BITS-1:0]         exponent_i,
  input  logic                        done_i,
  input  logic [rtmmp_pkg::OUT_W-1:0] last_digits_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);

  localparam int unsigned OUT_W = rtmmp_pkg::OUT_W;
  localparam int unsigned SHOWN = 20;

  typedef longint unsigned mat2_t [2][2];

  typedef struct {
    logic [EXP_BITS-1:0] exponent;
    logic [OUT_W-1:0]    digits;
  } digits_req_t;

  digits_req_t expected_digits [$];
  digits_req_t oldest;

  function automatic mat2_t mat_product(mat2_t x, mat2_t y);
    mat2_t r;
    longint unsigned m;
    m = MODULUS;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        r[i][j] = ((x[i][0] * y[0][j]) % m + (x[i][1] * y[1][j]) % m) % m;
      end
    end
    return r;
  endfunction

  // square-and-multiply over the bits of n-1, then apply to the start vector (3,1)
  function automatic logic [OUT_W-1:0] recurrence_last_digits(logic [EXP_BITS-1:0] n_exp);
    logic [EXP_BITS-1:0] steps;
    logic [OUT_W-1:0]    digits;
    mat2_t               acc;
    mat2_t               power;
    longint unsigned     m;
    longint unsigned     a_term;
    m = MODULUS;
    steps = (n_exp == '0) ? '0 : n_exp - 1'b1;
    acc[0][0] = 1 % m;
    acc[0][1] = 0;
    acc[1][0] = 0;
    acc[1][1] = 1 % m;
    power[0][0] = 3 % m;
    power[0][1] = 5 % m;
    power[1][0] = 1 % m;
    power[1][1] = 3 % m;
    for (int b = 0; b < EXP_BITS && b < 64; b++) begin
      if (steps[b]) acc = mat_product(acc, power);
      power = mat_product(power, power);
    end
    a_term = ((3 % m) * acc[0][0] + (1 % m) * acc[0][1]) % m;
    // a zero term gives m-1, never a negative value
    digits = OUT_W'((2 * a_term + m - 1) % m);
    return digits;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches_o < SHOWN) $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_digits.delete();
      pending_o <= 0;
    end else begin
      if (done_i !== 1'b0) begin
        if (done_i !== 1'b1) begin
          report_mismatch("result strobe is unknown");
        end else if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", last_digits_i));
        end else begin
          oldest = expected_digits.pop_front();
          checked_o++;
          if (last_digits_i !== oldest.digits) begin
            report_mismatch($sformatf("exponent %0d: last_digits %0d, expected %0d",
                                      oldest.exponent, last_digits_i, oldest.digits));
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_digits.push_back('{exponent: exponent_i,
                                    digits: recurrence_last_digits(exponent_i)});
      end
      pending_o <= expected_digits.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives exponent requests into the matrix power block and gives the verdict
module tb_top;

  localparam int unsigned EXP_BITS        = 31;
  localparam int unsigned MODULUS         = 1000;
  localparam int unsigned OUT_W           = rtmmp_pkg::OUT_W;
  localparam int unsigned RANDOM_REQUESTS = 926;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [EXP_BITS-1:0] exponent_i;
  logic                done_o;
  logic [OUT_W-1:0]    last_digits_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned requests;

  logic [EXP_BITS-1:0] directed_exponents [$];

  recurrence_term_mod_by_matrix_power #(
    .EXP_BITS(EXP_BITS),
    .MODULUS (MODULUS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .exponent_i   (exponent_i),
    .done_o       (done_o),
    .last_digits_o(last_digits_o)
  );

  last_digits_checker #(
    .EXP_BITS(EXP_BITS),
    .MODULUS (MODULUS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .exponent_i   (exponent_i),
    .done_i       (done_o),
    .last_digits_i(last_digits_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input logic [EXP_BITS-1:0] n_exp);
    start <= 1'b1;
    exponent_i <= n_exp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests++;
    @(negedge clk_i);
  endtask

  task automatic maybe_idle(input bit allow);
    int unsigned gap;
    if (allow && $urandom_range(99) < 37) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 800) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) begin
        exponent_i <= EXP_BITS'($urandom);
        @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [EXP_BITS-1:0] n_exp;
    int unsigned         width;
    start      = 1'b0;
    exponent_i = '0;
    rst_ni     = 1'b0;
    // extremes, the zero exponent, short exponents and alternating bit patterns
    directed_exponents = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7,
                           31'd8, 31'd9, 31'd16, 31'd17, 31'd255, 31'd256, 31'd1000,
                           31'd1001, 31'h4000_0000, 31'h4000_0001, 31'h7FFF_FFFF,
                           31'h7FFF_FFFE, 31'h5555_5555, 31'h2AAA_AAAA, 31'h0001_0000,
                           31'h7FFF_8000};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_exponents[k]) begin
      send_request(directed_exponents[k]);
      maybe_idle(k % 2);
    end
    wait_drained();

    // mostly short exponents with random content, the rest full width
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 450) wait_drained();
      width = ($urandom_range(99) < 60) ? $urandom_range(1, 12) : EXP_BITS;
      n_exp = EXP_BITS'($urandom);
      n_exp = n_exp >> (EXP_BITS - width);
      send_request(n_exp);
      maybe_idle(!(i >= 200 && i < 350));
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("covered %0d requests: zero and maximum exponents, bit patterns, random widths",
             requests);
    $display("%0d results compared, back-to-back and idle-separated requests", checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rtmmp_pkg.sv
rtl/core/rtmmp_modmul.sv
rtl/core/rtmmp_dp.sv
rtl/core/rtmmp_ctrl.sv
rtl/core/recurrence_term_mod_by_matrix_power.sv
tb/sv/last_digits_checker.sv
tb/sv/tb_top.sv
